// ===== rtl/core/rac_pkg.sv =====
`default_nettype none
package rac_pkg;

    localparam int MAX_RANGES = 64;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int ADDR_W     = 64;
    localparam int LEN_W      = 48;
    localparam int ALN_W      = 21;

    localparam logic [ALN_W-1:0] DEFAULT_ALIGN = ALN_W'(16);
    localparam logic [LEN_W-1:0] RESET_TOTAL   = LEN_W'(1048576);

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_REBUILD = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_EXACT = 2'd2;
    localparam logic [1:0] FIT_LAST  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_TOTAL = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
        logic              taken;
        logic [ALN_W-1:0]  aln;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              fit;
        logic [ALN_W-1:0]  pad;
        logic [LEN_W-1:0]  waste;
    } fit_t;

endpackage
`default_nettype wire

// ===== rtl/core/range_allocator_fit_coalesce.sv =====
// Query and rebuild go from idle straight to the response state; alloc and free walk the range
// table (table scan, shift of later entries, largest-free rescan, one table entry per cycle).
// Throughput: one command at a time; the next command is taken once the result is
// registered, set by the single read and single write port of the range table.
// Reset: control cleared; the first cycle after reset writes table entry 0 with
// input stalled.
`default_nettype none
module range_allocator_fit_coalesce (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic                          cfg_index,
    input  wire logic [63:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    command,
    input  wire logic [rac_pkg::LEN_W-1:0]     request_size,
    input  wire logic [rac_pkg::ALN_W-1:0]     alignment,
    input  wire logic [1:0]                    fit_policy,
    input  wire logic [rac_pkg::ADDR_W-1:0]    free_address,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         status,
    output logic [rac_pkg::ADDR_W-1:0]         granted_address,
    output logic [rac_pkg::LEN_W-1:0]          largest_free,
    output logic [rac_pkg::LEN_W-1:0]          free_total,
    output logic [rac_pkg::LEN_W-1:0]          used_total
);

    localparam int IW = rac_pkg::IDX_W;
    localparam int CW = rac_pkg::CNT_W;
    localparam int LW = rac_pkg::LEN_W;
    localparam int AW = rac_pkg::ADDR_W;
    localparam int NW = rac_pkg::ALN_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_ACHK, S_SHUP, S_PUT,
        S_FRD, S_FFIX, S_SHDN, S_LARGE, S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] base_reg, base_next;
    logic [LW-1:0] total_reg, total_next;
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] used_reg, used_next;
    logic [LW-1:0] free_reg, free_next;
    logic [LW-1:0] large_reg, large_next;

    logic          is_alloc_reg, is_alloc_next;
    logic [LW-1:0] size_reg, size_next;
    logic [NW-1:0] align_reg, align_next;
    logic [NW-1:0] mask_reg, mask_next;
    logic [1:0]    policy_reg, policy_next;
    logic [AW-1:0] faddr_reg, faddr_next;

    logic [CW-1:0] iss_reg, iss_next;
    logic          pv_reg, pv_next;
    logic [IW-1:0] pi_reg, pi_next;
    logic          found_reg, found_next;
    logic [IW-1:0] c_reg, c_next;
    logic [AW-1:0] cs_reg, cs_next;
    logic [LW-1:0] cl_reg, cl_next;
    logic [NW-1:0] cpad_reg, cpad_next;
    logic [LW-1:0] waste_reg, waste_next;
    logic [AW-1:0] pstart_reg, pstart_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic          ptaken_reg, ptaken_next;
    logic [1:0]    need_reg, need_next;
    logic          padnz_reg, padnz_next;
    logic          remnz_reg, remnz_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic [1:0]    step_reg, step_next;
    logic          nok_reg, nok_next;
    logic [1:0]    k_reg, k_next;
    logic [LW-1:0] best_reg, best_next;

    logic [1:0]    st_reg, st_next;
    logic [AW-1:0] grant_reg, grant_next;

    logic          ov_reg, ov_next;
    logic [1:0]    ostat_reg, ostat_next;
    logic [AW-1:0] ogrant_reg, ogrant_next;
    logic [LW-1:0] olarge_reg, olarge_next;
    logic [LW-1:0] ofree_reg, ofree_next;
    logic [LW-1:0] oused_reg, oused_next;

    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    rac_pkg::entry_t              wr_ent;
    logic                         rd_en;
    logic [IW-1:0]                rd_addr;
    logic [rac_pkg::ENTRY_W-1:0]  rd_data;
    rac_pkg::entry_t              rd_ent;
    rac_pkg::fit_t                fr;

    assign rd_ent = rd_data;

    rac_table_ram #(
        .DEPTH (rac_pkg::MAX_RANGES),
        .WIDTH (rac_pkg::ENTRY_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rac_fit_eval u_fit (
        .ent  (rd_ent),
        .size (size_reg),
        .mask (mask_reg),
        .res  (fr)
    );

    logic [NW-1:0]   a_in;
    logic            take;
    logic            stop;
    logic            pol12;
    logic [LW-1:0]   rem_c;
    logic [1:0]      need_c;
    logic [CW:0]     need_sum;
    logic            nfree;
    logic [LW-1:0]   merged;
    logic [IW-1:0]   tk;
    logic [CW-1:0]   c1;

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        total_next  = total_reg;
        count_next  = count_reg;
        used_next   = used_reg;
        free_next   = free_reg;
        large_next  = large_reg;
        is_alloc_next = is_alloc_reg;
        size_next   = size_reg;
        align_next  = align_reg;
        mask_next   = mask_reg;
        policy_next = policy_reg;
        faddr_next  = faddr_reg;
        iss_next    = iss_reg;
        pv_next     = 1'b0;
        pi_next     = pi_reg;
        found_next  = found_reg;
        c_next      = c_reg;
        cs_next     = cs_reg;
        cl_next     = cl_reg;
        cpad_next   = cpad_reg;
        waste_next  = waste_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        ptaken_next = ptaken_reg;
        need_next   = need_reg;
        padnz_next  = padnz_reg;
        remnz_next  = remnz_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        nok_next    = nok_reg;
        k_next      = k_reg;
        best_next   = best_reg;
        st_next     = st_reg;
        grant_next  = grant_reg;
        ov_next     = ov_reg && out_stall;
        ostat_next  = ostat_reg;
        ogrant_next = ogrant_reg;
        olarge_next = olarge_reg;
        ofree_next  = ofree_reg;
        oused_next  = oused_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_ent  = '0;
        rd_en   = 1'b0;
        rd_addr = '0;

        a_in     = (alignment == '0) ? rac_pkg::DEFAULT_ALIGN : alignment;
        pol12    = (policy_reg == rac_pkg::FIT_BEST) || (policy_reg == rac_pkg::FIT_EXACT);
        take     = fr.fit && (!pol12 || !found_reg || (fr.waste < waste_reg));
        stop     = 1'b0;
        rem_c    = cl_reg - LW'(cpad_reg) - size_reg;
        need_c   = 2'((cpad_reg != '0)) + 2'((rem_c != '0));
        need_sum = (CW+1)'(count_reg) + (CW+1)'(need_c);
        nfree    = nok_reg && !rd_ent.taken;
        merged   = cl_reg + (nfree ? rd_ent.len : '0);
        tk       = c_reg + IW'(padnz_reg);
        c1       = CW'(c_reg) + 1'b1;

        if (cfg_wen)
        begin
            if (cfg_index == rac_pkg::CFG_BASE)
            begin
                base_next = cfg_data;
            end
            else
            begin
                total_next = cfg_data[LW-1:0];
            end
        end

        case (state_reg)
            S_INIT:
            begin
                wr_en        = 1'b1;
                wr_ent.start = '0;
                wr_ent.len   = rac_pkg::RESET_TOTAL;
                state_next   = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    grant_next    = '0;
                    st_next       = rac_pkg::ST_OK;
                    is_alloc_next = (command == rac_pkg::CMD_ALLOC);
                    size_next     = request_size;
                    align_next    = a_in;
                    mask_next     = a_in - 1'b1;
                    policy_next   = fit_policy;
                    faddr_next    = free_address;
                    iss_next      = '0;
                    found_next    = 1'b0;
                    ptaken_next   = 1'b1;
                    state_next    = S_RESP;
                    case (command)
                        rac_pkg::CMD_ALLOC:
                        begin
                            if (request_size == '0 || (a_in & (a_in - 1'b1)) != '0)
                            begin
                                st_next = rac_pkg::ST_INVAL;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        rac_pkg::CMD_FREE:
                        begin
                            state_next = S_SCAN;
                        end
                        rac_pkg::CMD_REBUILD:
                        begin
                            if (total_reg == '0)
                            begin
                                st_next = rac_pkg::ST_INVAL;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_ent.start = base_reg;
                                wr_ent.len   = total_reg;
                                count_next   = CW'(1);
                                used_next    = '0;
                                free_next    = total_reg;
                                large_next   = total_reg;
                            end
                        end
                        default:
                        begin
                            st_next = rac_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (pv_reg)
                begin
                    if (is_alloc_reg)
                    begin
                        if (take)
                        begin
                            found_next = 1'b1;
                            c_next     = pi_reg;
                            cs_next    = rd_ent.start;
                            cl_next    = rd_ent.len;
                            cpad_next  = fr.pad;
                            waste_next = fr.waste;
                        end
                        stop = fr.fit && ((policy_reg == rac_pkg::FIT_FIRST)
                               || (pol12 && take && fr.waste == '0));
                    end
                    else if (rd_ent.taken && rd_ent.start == faddr_reg)
                    begin
                        stop    = 1'b1;
                        c_next  = pi_reg;
                        cs_next = rd_ent.start;
                        cl_next = rd_ent.len;
                    end
                    else
                    begin
                        pstart_next = rd_ent.start;
                        plen_next   = rd_ent.len;
                        ptaken_next = rd_ent.taken;
                    end
                end
                if (stop)
                begin
                    state_next = is_alloc_reg ? S_ACHK : S_FRD;
                end
                else if (!pv_reg && iss_reg >= count_reg)
                begin
                    if (is_alloc_reg && found_reg)
                    begin
                        state_next = S_ACHK;
                    end
                    else
                    begin
                        st_next    = is_alloc_reg ? rac_pkg::ST_NOMEM : rac_pkg::ST_INVAL;
                        state_next = S_RESP;
                    end
                end
                else if (iss_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = iss_reg[IW-1:0];
                    pv_next  = 1'b1;
                    pi_next  = iss_reg[IW-1:0];
                    iss_next = iss_reg + 1'b1;
                end
            end
            S_ACHK:
            begin
                padnz_next = (cpad_reg != '0);
                remnz_next = (rem_c != '0);
                rem_next   = rem_c;
                need_next  = need_c;
                iss_next   = count_reg;
                step_next  = '0;
                if (need_sum > (CW+1)'(rac_pkg::MAX_RANGES))
                begin
                    st_next    = rac_pkg::ST_NOMEM;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SHUP;
                end
            end
            S_SHUP:
            begin
                if (pv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pi_reg + IW'(need_reg);
                    wr_ent  = rd_ent;
                end
                if (need_reg != '0 && iss_reg > c1)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = IW'(iss_reg - 1'b1);
                    pv_next  = 1'b1;
                    pi_next  = IW'(iss_reg - 1'b1);
                    iss_next = iss_reg - 1'b1;
                end
                else if (!pv_reg)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        wr_en        = padnz_reg;
                        wr_addr      = c_reg;
                        wr_ent.start = cs_reg;
                        wr_ent.len   = LW'(cpad_reg);
                    end
                    2'd1:
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = tk;
                        wr_ent.start = cs_reg + AW'(cpad_reg);
                        wr_ent.len   = size_reg;
                        wr_ent.taken = 1'b1;
                        wr_ent.aln   = align_reg;
                    end
                    default:
                    begin
                        wr_en        = remnz_reg;
                        wr_addr      = tk + 1'b1;
                        wr_ent.start = cs_reg + AW'(cpad_reg) + AW'(size_reg);
                        wr_ent.len   = rem_reg;
                        count_next   = count_reg + CW'(need_reg);
                        used_next    = used_reg + size_reg;
                        free_next    = (free_reg >= size_reg) ? free_reg - size_reg : free_reg;
                        grant_next   = cs_reg + AW'(cpad_reg);
                        iss_next     = '0;
                        best_next    = '0;
                        state_next   = S_LARGE;
                    end
                endcase
            end
            S_FRD:
            begin
                nok_next   = (c1 < count_reg);
                rd_en      = 1'b1;
                rd_addr    = IW'(c1);
                state_next = S_FFIX;
            end
            S_FFIX:
            begin
                used_next = used_reg - cl_reg;
                free_next = free_reg + cl_reg;
                wr_en     = 1'b1;
                if (c_reg != '0 && !ptaken_reg)
                begin
                    wr_addr      = c_reg - 1'b1;
                    wr_ent.start = pstart_reg;
                    wr_ent.len   = plen_reg + merged;
                    k_next       = 2'd1 + 2'(nfree);
                end
                else
                begin
                    wr_addr      = c_reg;
                    wr_ent.start = cs_reg;
                    wr_ent.len   = merged;
                    k_next       = 2'(nfree);
                end
                iss_next   = c1 + CW'(nfree);
                state_next = S_SHDN;
            end
            S_SHDN:
            begin
                if (pv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pi_reg - IW'(k_reg);
                    wr_ent  = rd_ent;
                end
                if (k_reg != '0 && iss_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = iss_reg[IW-1:0];
                    pv_next  = 1'b1;
                    pi_next  = iss_reg[IW-1:0];
                    iss_next = iss_reg + 1'b1;
                end
                else if (!pv_reg)
                begin
                    count_next = count_reg - CW'(k_reg);
                    iss_next   = '0;
                    best_next  = '0;
                    state_next = S_LARGE;
                end
            end
            S_LARGE:
            begin
                if (pv_reg && !rd_ent.taken && rd_ent.len > best_reg)
                begin
                    best_next = rd_ent.len;
                end
                if (iss_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = iss_reg[IW-1:0];
                    pv_next  = 1'b1;
                    iss_next = iss_reg + 1'b1;
                end
                else if (!pv_reg)
                begin
                    large_next = best_reg;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next     = 1'b1;
                    ostat_next  = st_reg;
                    ogrant_next = (st_reg == rac_pkg::ST_OK) ? grant_reg : '0;
                    olarge_next = large_reg;
                    ofree_next  = free_reg;
                    oused_next  = used_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            base_reg     <= '0;
            total_reg    <= rac_pkg::RESET_TOTAL;
            count_reg    <= CW'(1);
            used_reg     <= '0;
            free_reg     <= rac_pkg::RESET_TOTAL;
            large_reg    <= rac_pkg::RESET_TOTAL;
            pv_reg       <= 1'b0;
            iss_reg      <= '0;
            found_reg    <= 1'b0;
            step_reg     <= '0;
            need_reg     <= '0;
            k_reg        <= '0;
            ov_reg       <= 1'b0;
            is_alloc_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            total_reg    <= total_next;
            count_reg    <= count_next;
            used_reg     <= used_next;
            free_reg     <= free_next;
            large_reg    <= large_next;
            pv_reg       <= pv_next;
            iss_reg      <= iss_next;
            found_reg    <= found_next;
            step_reg     <= step_next;
            need_reg     <= need_next;
            k_reg        <= k_next;
            ov_reg       <= ov_next;
            is_alloc_reg <= is_alloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        align_reg  <= align_next;
        mask_reg   <= mask_next;
        policy_reg <= policy_next;
        faddr_reg  <= faddr_next;
        pi_reg     <= pi_next;
        c_reg      <= c_next;
        cs_reg     <= cs_next;
        cl_reg     <= cl_next;
        cpad_reg   <= cpad_next;
        waste_reg  <= waste_next;
        pstart_reg <= pstart_next;
        plen_reg   <= plen_next;
        ptaken_reg <= ptaken_next;
        padnz_reg  <= padnz_next;
        remnz_reg  <= remnz_next;
        rem_reg    <= rem_next;
        nok_reg    <= nok_next;
        best_reg   <= best_next;
        st_reg     <= st_next;
        grant_reg  <= grant_next;
        ostat_reg  <= ostat_next;
        ogrant_reg <= ogrant_next;
        olarge_reg <= olarge_next;
        ofree_reg  <= ofree_next;
        oused_reg  <= oused_next;
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = ov_reg;
    assign status          = ostat_reg;
    assign granted_address = ogrant_reg;
    assign largest_free    = olarge_reg;
    assign free_total      = ofree_reg;
    assign used_total      = oused_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rac_table_ram.sv =====
`default_nettype none
module rac_table_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 134
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rac_fit_eval.sv =====
`default_nettype none
module rac_fit_eval (
    input  wire rac_pkg::entry_t               ent,
    input  wire logic [rac_pkg::LEN_W-1:0]     size,
    input  wire logic [rac_pkg::ALN_W-1:0]     mask,
    output rac_pkg::fit_t                      res
);

    logic [rac_pkg::ALN_W-1:0] pad;
    logic [rac_pkg::LEN_W:0]   need;

    always_comb
    begin
        pad       = (~ent.start[rac_pkg::ALN_W-1:0] + 1'b1) & mask;
        need      = {1'b0, size} + (rac_pkg::LEN_W+1)'(pad);
        res.fit   = !ent.taken && ({1'b0, ent.len} >= need);
        res.pad   = pad;
        res.waste = ent.len - need[rac_pkg::LEN_W-1:0];
    end

endmodule
`default_nettype wire
